// ===== sv/segment_obb_intersection_2d_macros.svh =====
// ----------------------------------------------------------------------------
// segment_obb_intersection_2d assertion macros
// Same-cycle and next-cycle implication checks on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_OBB_INTERSECTION_2D_MACROS_SVH
`define SEGMENT_OBB_INTERSECTION_2D_MACROS_SVH

`define SOBI_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sobi check failed");

`define SOBI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sobi check failed");

`endif

// ===== sv/sobi_pkg.sv =====
// ----------------------------------------------------------------------------
// sobi_pkg
// Shared types and constants of the segment / oriented box slab test.
// ----------------------------------------------------------------------------
package sobi_pkg;

  localparam int AXIS_ONE  = 16384;
  localparam int TQ_BITS   = 47;
  localparam int TW        = TQ_BITS + 2;
  localparam int DIV_LAT   = TQ_BITS + 3;
  localparam int FDEPTH    = 8;
  localparam int FCNT_W    = $clog2(FDEPTH) + 1;
  localparam int CFG_IDX_W = 3;
  localparam int OUT_TDATA_W = 56;

  localparam logic signed [TW-1:0] T_BIG = TW'((64'd1 << TQ_BITS) + 64'd1);
  localparam logic signed [TW-1:0] T_ONE = TW'(65536);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_EXTENT_X = 3'd2,
    REG_EXTENT_Y = 3'd3,
    REG_AXIS_COS = 3'd4,
    REG_AXIS_SIN = 3'd5,
    REG_PAR_THR  = 3'd6
  } sobi_reg_e;

  typedef struct packed {
    logic [30:0]        ext_x;
    logic [30:0]        ext_y;
    logic signed [15:0] cs;
    logic signed [15:0] sn;
    logic [15:0]        thr;
  } sobi_box_t;

  typedef struct packed {
    logic [1:0]         par;
    logic [1:0]         pgt;
    logic [1:0]         ins;
    logic signed [15:0] n0x;
    logic signed [15:0] n0y;
    logic signed [15:0] n1x;
    logic signed [15:0] n1y;
  } sobi_flags_t;

  function automatic logic signed [15:0] sat_axis(input logic signed [15:0] a);
    logic signed [15:0] r;
    r = a;
    if (a > 16'sd16384) r = 16'sd16384;
    if (a < -16'sd16384) r = -16'sd16384;
    return r;
  endfunction

endpackage

// ===== sv/segment_obb_intersection_2d.sv =====
// ----------------------------------------------------------------------------
// segment_obb_intersection_2d
// Slab test of streamed segments against one configured oriented 2D box.
// ----------------------------------------------------------------------------
// Takes one segment per cycle while in_tready is high and returns one result
// per segment in order. A segment passes the projection registers, the queue,
// the divider pipeline and one output register; the bit-per-stage slab time
// dividers (47 quotient stages) are the longest part. Config writes are taken
// any cycle but must only happen while the block is empty.
module segment_obb_intersection_2d import sobi_pkg::*; #(
  parameter int COORD_WIDTH = 32,
  localparam int IN_TW  = ((4 * COORD_WIDTH + 7) / 8) * 8,
  localparam int CFG_DW = (COORD_WIDTH > 31) ? COORD_WIDTH : 31
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TW-1:0]       in_tdata,   // start_x, start_y, end_x, end_y
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // hit, hit_time, normal_x, normal_y, start_inside
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DW-1:0]      cfg_data
);

  localparam int CW = COORD_WIDTH;
  localparam int PW = CW + 4;
  localparam int NW = ((PW > 32) ? PW : 32) + 1;
  localparam int QW = 4 * NW + 2 * PW + $bits(sobi_flags_t);

  logic signed [CW-1:0] center_x_r, center_y_r;
  logic [30:0]          extent_x_r, extent_y_r;
  logic [15:0]          axis_cos_r, axis_sin_r, thr_r;
  sobi_box_t            box;

  logic                 accept, push, pop, q_valid;
  logic [FCNT_W-1:0]    q_count;
  logic [2:0]           inflight;
  logic signed [NW-1:0] f_nn0, f_nf0, f_nn1, f_nf1, b_nn0, b_nf0, b_nn1, b_nf1;
  logic signed [PW-1:0] f_d0, f_d1, b_d0, b_d1;
  sobi_flags_t          f_flags, b_flags;
  logic [QW-1:0]        q_din, q_dout;

  logic               r_hit, r_inside;
  logic [16:0]        r_time;
  logic signed [15:0] r_nx, r_ny;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
      extent_x_r <= '0;
      extent_y_r <= '0;
      axis_cos_r <= 16'(AXIS_ONE);
      axis_sin_r <= '0;
      thr_r      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (sobi_reg_e'(cfg_index))
        REG_CENTER_X: center_x_r <= cfg_data[CW-1:0];
        REG_CENTER_Y: center_y_r <= cfg_data[CW-1:0];
        REG_EXTENT_X: extent_x_r <= cfg_data[30:0];
        REG_EXTENT_Y: extent_y_r <= cfg_data[30:0];
        REG_AXIS_COS: axis_cos_r <= cfg_data[15:0];
        REG_AXIS_SIN: axis_sin_r <= cfg_data[15:0];
        REG_PAR_THR:  thr_r      <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    box.ext_x = extent_x_r;
    box.ext_y = extent_y_r;
    box.cs    = sat_axis(axis_cos_r);
    box.sn    = sat_axis(axis_sin_r);
    box.thr   = thr_r;
  end

  assign in_tready = ((FCNT_W+1)'(q_count) + (FCNT_W+1)'(inflight)) < (FCNT_W+1)'(FDEPTH);
  assign accept    = in_tvalid && in_tready;

  sobi_front #(.CW(CW)) u_front (
    .clk(clk), .rst_n(rst_n), .accept(accept),
    .sx(in_tdata[CW-1:0]), .sy(in_tdata[2*CW-1:CW]),
    .ex(in_tdata[3*CW-1:2*CW]), .ey(in_tdata[4*CW-1:3*CW]),
    .cx(center_x_r), .cy(center_y_r), .box(box),
    .push(push), .nn0(f_nn0), .nf0(f_nf0), .nn1(f_nn1), .nf1(f_nf1),
    .d0(f_d0), .d1(f_d1), .flags(f_flags), .inflight(inflight)
  );

  assign q_din = {f_flags, f_d1, f_d0, f_nf1, f_nn1, f_nf0, f_nn0};

  sobi_fifo #(.W(QW), .DEPTH(FDEPTH)) u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .din(q_din), .pop(pop),
    .dout(q_dout), .valid(q_valid), .count(q_count)
  );

  assign {b_flags, b_d1, b_d0, b_nf1, b_nn1, b_nf0, b_nn0} = q_dout;

  sobi_back #(.CW(CW)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(pop),
    .nn0(b_nn0), .nf0(b_nf0), .nn1(b_nn1), .nf1(b_nf1),
    .d0(b_d0), .d1(b_d1), .flags(b_flags),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .hit(r_hit), .hit_time(r_time), .normal_x(r_nx), .normal_y(r_ny),
    .start_inside(r_inside)
  );

  assign out_tdata = {5'b0, r_inside, r_ny, r_nx, r_time, r_hit};

endmodule

// ===== sv/sobi_fifo.sv =====
// ----------------------------------------------------------------------------
// sobi_fifo
// Small register queue between the projection front and the divide back.
// ----------------------------------------------------------------------------
module sobi_fifo import sobi_pkg::*; #(
  parameter int W     = 8,
  parameter int DEPTH = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [W-1:0]               din,
  input  logic                       pop,
  output logic [W-1:0]               dout,
  output logic                       valid,
  output logic [$clog2(DEPTH):0]     count
);

  localparam int AW = $clog2(DEPTH);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + AW'(1);
      if (pop) rp_r <= rp_r + AW'(1);
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= din;
  end

  assign dout  = mem_r[rp_r];
  assign valid = (cnt_r != '0);
  assign count = cnt_r;

endmodule

// ===== sv/sobi_div.sv =====
// ----------------------------------------------------------------------------
// sobi_div
// Pipelined signed Q32.16 slab time divider, one quotient bit per stage,
// magnitude saturated at 2^47.
// ----------------------------------------------------------------------------
module sobi_div import sobi_pkg::*; #(
  parameter int NW = 37,
  parameter int DW = 36
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [NW-1:0] num,
  input  logic signed [DW-1:0] den,
  output logic signed [TW-1:0] quo
);

  logic [NW-1:0] un_s0;
  logic [DW-1:0] ud_s0;
  logic          ng_s0;

  logic [DW-1:0]      rem_a [TQ_BITS+1];
  logic [TQ_BITS-1:0] q_a   [TQ_BITS+1];
  logic [NW-1:0]      un_a  [TQ_BITS+1];
  logic [DW-1:0]      ud_a  [TQ_BITS+1];
  logic               ng_a  [TQ_BITS+1];
  logic               sat_a [TQ_BITS+1];

  logic [DW-1:0]    rem_nx [1:TQ_BITS];
  logic [TQ_BITS:1] ge;

  logic [NW+31:0] ux0;
  logic [DW-1:0]  rem_init;
  logic           sat_init;
  logic [TW-1:0]  mag;
  logic signed [TW-1:0] quo_r;

  assign ux0      = {32'b0, un_s0};
  assign rem_init = DW'(ux0[NW+31:31]);
  assign sat_init = (DW+31)'(un_s0) >= {ud_s0, 31'b0};

  genvar j;
  for (j = 1; j <= TQ_BITS; j++) begin : g_stage
    localparam int BI = TQ_BITS - j;
    logic [NW+31:0] ux;
    logic           nb;
    logic [DW:0]    trial;
    assign ux = {32'b0, un_a[j-1]};
    if (BI >= 16) begin : g_bit
      assign nb = ux[BI-16];
    end else begin : g_zero
      assign nb = 1'b0;
    end
    assign trial     = {rem_a[j-1], nb};
    assign ge[j]     = trial >= {1'b0, ud_a[j-1]};
    assign rem_nx[j] = ge[j] ? DW'(trial - {1'b0, ud_a[j-1]}) : DW'(trial);
  end

  assign mag = sat_a[TQ_BITS] ? (TW'(1) << TQ_BITS) : TW'(q_a[TQ_BITS]);

  always_ff @(posedge clk) begin
    if (en) begin
      un_s0 <= num[NW-1] ? NW'(-num) : NW'(num);
      ud_s0 <= den[DW-1] ? DW'(-den) : DW'(den);
      ng_s0 <= num[NW-1] ^ den[DW-1];
      rem_a[0] <= rem_init;
      q_a[0]   <= '0;
      un_a[0]  <= un_s0;
      ud_a[0]  <= ud_s0;
      ng_a[0]  <= ng_s0;
      sat_a[0] <= sat_init;
      for (int k = 1; k <= TQ_BITS; k++) begin
        rem_a[k] <= rem_nx[k];
        q_a[k]   <= {q_a[k-1][TQ_BITS-2:0], ge[k]};
        un_a[k]  <= un_a[k-1];
        ud_a[k]  <= ud_a[k-1];
        ng_a[k]  <= ng_a[k-1];
        sat_a[k] <= sat_a[k-1];
      end
      quo_r <= ng_a[TQ_BITS] ? -$signed(mag) : $signed(mag);
    end
  end

  assign quo = quo_r;

endmodule

// ===== sv/sobi_front.sv =====
// ----------------------------------------------------------------------------
// sobi_front
// Projects each segment on both box axes and classifies the slabs:
// parallel, outside and inside tests, near/far numerators and entry normals.
// ----------------------------------------------------------------------------
module sobi_front import sobi_pkg::*; #(
  parameter int CW = 32,
  localparam int PW = CW + 4,
  localparam int NW = ((PW > 32) ? PW : 32) + 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic signed [CW-1:0] sx,
  input  logic signed [CW-1:0] sy,
  input  logic signed [CW-1:0] ex,
  input  logic signed [CW-1:0] ey,
  input  logic signed [CW-1:0] cx,
  input  logic signed [CW-1:0] cy,
  input  sobi_box_t            box,
  output logic                 push,
  output logic signed [NW-1:0] nn0,
  output logic signed [NW-1:0] nf0,
  output logic signed [NW-1:0] nn1,
  output logic signed [NW-1:0] nf1,
  output logic signed [PW-1:0] d0,
  output logic signed [PW-1:0] d1,
  output sobi_flags_t          flags,
  output logic [2:0]           inflight
);

  localparam int OW = CW + 1;
  localparam int MW = OW + 16;
  localparam int SW = MW + 1;

  logic va_r, vb_r, vc_r, vd_r;
  logic signed [OW-1:0] ox_r, oy_r, dx_r, dy_r;
  logic signed [MW-1:0] pxc_r, pys_r, pxs_r, pyc_r, dxc_r, dys_r, dxs_r, dyc_r;
  logic signed [PW-1:0] p0_r, p1_r, q0_r, q1_r;

  logic signed [NW-1:0] nn0_r, nf0_r, nn1_r, nf1_r;
  logic signed [PW-1:0] d0_r, d1_r;
  sobi_flags_t          fl_r;

  logic [PW-1:0]        pa0, pa1, da0, da1;
  logic signed [NW-1:0] pe0, pe1, ee0, ee1, lo0, hi0, lo1, hi1;
  logic                 dp0, dp1;
  sobi_flags_t          fl_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      va_r <= accept;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ox_r <= OW'(sx) - OW'(cx);
      oy_r <= OW'(sy) - OW'(cy);
      dx_r <= OW'(ex) - OW'(sx);
      dy_r <= OW'(ey) - OW'(sy);
    end
    pxc_r <= ox_r * box.cs;
    pys_r <= oy_r * box.sn;
    pxs_r <= ox_r * box.sn;
    pyc_r <= oy_r * box.cs;
    dxc_r <= dx_r * box.cs;
    dys_r <= dy_r * box.sn;
    dxs_r <= dx_r * box.sn;
    dyc_r <= dy_r * box.cs;
    p0_r  <= PW'((SW'(pxc_r) + SW'(pys_r)) >>> 14);
    p1_r  <= PW'((SW'(pyc_r) - SW'(pxs_r)) >>> 14);
    q0_r  <= PW'((SW'(dxc_r) + SW'(dys_r)) >>> 14);
    q1_r  <= PW'((SW'(dyc_r) - SW'(dxs_r)) >>> 14);
    nn0_r <= dp0 ? lo0 : hi0;
    nf0_r <= dp0 ? hi0 : lo0;
    nn1_r <= dp1 ? lo1 : hi1;
    nf1_r <= dp1 ? hi1 : lo1;
    d0_r  <= q0_r;
    d1_r  <= q1_r;
    fl_r  <= fl_nxt;
  end

  always_comb begin
    pa0 = p0_r[PW-1] ? PW'(-p0_r) : PW'(p0_r);
    pa1 = p1_r[PW-1] ? PW'(-p1_r) : PW'(p1_r);
    da0 = q0_r[PW-1] ? PW'(-q0_r) : PW'(q0_r);
    da1 = q1_r[PW-1] ? PW'(-q1_r) : PW'(q1_r);
    dp0 = !q0_r[PW-1] && (q0_r != '0);
    dp1 = !q1_r[PW-1] && (q1_r != '0);
    pe0 = NW'(p0_r);
    pe1 = NW'(p1_r);
    ee0 = NW'(box.ext_x);
    ee1 = NW'(box.ext_y);
    lo0 = -ee0 - pe0;
    hi0 = ee0 - pe0;
    lo1 = -ee1 - pe1;
    hi1 = ee1 - pe1;
    fl_nxt.par[0] = da0 <= PW'(box.thr);
    fl_nxt.par[1] = da1 <= PW'(box.thr);
    fl_nxt.pgt[0] = NW'(pa0) > NW'(box.ext_x);
    fl_nxt.pgt[1] = NW'(pa1) > NW'(box.ext_y);
    fl_nxt.ins[0] = NW'(pa0) < NW'(box.ext_x);
    fl_nxt.ins[1] = NW'(pa1) < NW'(box.ext_y);
    fl_nxt.n0x = dp0 ? -box.cs : box.cs;
    fl_nxt.n0y = dp0 ? -box.sn : box.sn;
    fl_nxt.n1x = dp1 ? box.sn : -box.sn;
    fl_nxt.n1y = dp1 ? -box.cs : box.cs;
  end

  assign push     = vd_r;
  assign nn0      = nn0_r;
  assign nf0      = nf0_r;
  assign nn1      = nn1_r;
  assign nf1      = nf1_r;
  assign d0       = d0_r;
  assign d1       = d1_r;
  assign flags    = fl_r;
  assign inflight = 3'(va_r) + 3'(vb_r) + 3'(vc_r) + 3'(vd_r);

endmodule

// ===== sv/sobi_back.sv =====
// ----------------------------------------------------------------------------
// sobi_back
// Divides the slab times, intersects the slabs and holds the result
// register toward the output stream.
// ----------------------------------------------------------------------------
module sobi_back import sobi_pkg::*; #(
  parameter int CW = 32,
  localparam int PW = CW + 4,
  localparam int NW = ((PW > 32) ? PW : 32) + 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_pop,
  input  logic signed [NW-1:0] nn0,
  input  logic signed [NW-1:0] nf0,
  input  logic signed [NW-1:0] nn1,
  input  logic signed [NW-1:0] nf1,
  input  logic signed [PW-1:0] d0,
  input  logic signed [PW-1:0] d1,
  input  sobi_flags_t          flags,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 hit,
  output logic [16:0]          hit_time,
  output logic signed [15:0]   normal_x,
  output logic signed [15:0]   normal_y,
  output logic                 start_inside
);

  logic en;
  logic [DIV_LAT-1:0] vld_r;
  sobi_flags_t        fl_r [DIV_LAT];
  sobi_flags_t        f;
  logic               out_valid_r;

  logic signed [TW-1:0] tn0, tf0, tn1, tf1, e0, l0, ent, lv;
  logic signed [15:0]   nx0, ny0, nxs, nys;
  logic                 take1, miss, ins_all;

  logic               hit_r, ins_r;
  logic [16:0]        time_r;
  logic signed [15:0] nx_r, ny_r;

  assign en    = !out_valid_r || out_ready;
  assign q_pop = q_valid && en;

  sobi_div #(.NW(NW), .DW(PW)) u_div_n0 (.clk(clk), .en(en), .num(nn0), .den(d0), .quo(tn0));
  sobi_div #(.NW(NW), .DW(PW)) u_div_f0 (.clk(clk), .en(en), .num(nf0), .den(d0), .quo(tf0));
  sobi_div #(.NW(NW), .DW(PW)) u_div_n1 (.clk(clk), .en(en), .num(nn1), .den(d1), .quo(tn1));
  sobi_div #(.NW(NW), .DW(PW)) u_div_f1 (.clk(clk), .en(en), .num(nf1), .den(d1), .quo(tf1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[DIV_LAT-2:0], q_pop};
      out_valid_r <= vld_r[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fl_r[0] <= flags;
      for (int k = 1; k < DIV_LAT; k++) fl_r[k] <= fl_r[k-1];
      hit_r  <= !miss;
      time_r <= (miss || ent[TW-1]) ? 17'd0 : ent[16:0];
      nx_r   <= (miss || ins_all) ? 16'sd0 : nxs;
      ny_r   <= (miss || ins_all) ? 16'sd0 : nys;
      ins_r  <= !miss && ins_all;
    end
  end

  always_comb begin
    f     = fl_r[DIV_LAT-1];
    e0    = f.par[0] ? -T_BIG : tn0;
    l0    = f.par[0] ? T_BIG : tf0;
    nx0   = f.par[0] ? 16'sd0 : f.n0x;
    ny0   = f.par[0] ? 16'sd0 : f.n0y;
    take1 = !f.par[1] && (tn1 > e0);
    ent   = take1 ? tn1 : e0;
    nxs   = take1 ? f.n1x : nx0;
    nys   = take1 ? f.n1y : ny0;
    lv    = (!f.par[1] && (tf1 < l0)) ? tf1 : l0;
    ins_all = &f.ins;
    miss  = (f.par[0] && f.pgt[0]) || (f.par[1] && f.pgt[1]) ||
            (ent > lv) || lv[TW-1] || (ent > T_ONE);
  end

  assign out_valid    = out_valid_r;
  assign hit          = hit_r;
  assign hit_time     = time_r;
  assign normal_x     = nx_r;
  assign normal_y     = ny_r;
  assign start_inside = ins_r;

endmodule

// ===== sv/sobi_checker.sv =====
// ----------------------------------------------------------------------------
// sobi_checker
// Port-level checks of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "segment_obb_intersection_2d_macros.svh"

module sobi_checker import sobi_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  `SOBI_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)
  `SOBI_ASSERT_NEXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata))
  `SOBI_ASSERT_SAME(a_miss_zero, out_tvalid && !out_tdata[0], out_tdata[50:1] == 50'd0)
  `SOBI_ASSERT_SAME(a_inside_norm, out_tvalid && out_tdata[50], out_tdata[0] && out_tdata[49:18] == 32'd0)
  `SOBI_ASSERT_SAME(a_time_range, out_tvalid, out_tdata[17:1] <= 17'd65536)

endmodule

bind segment_obb_intersection_2d sobi_checker u_sobi_checker (
  .clk(clk), .rst_n(rst_n), .out_tvalid(out_tvalid),
  .out_tready(out_tready), .out_tdata(out_tdata)
);
